>>> rtl/sct_pkg.sv
// Package for the shell command tokenizer: character codes, result kinds and the
// bundle type that carries one word's results from the front end to the back end.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sct_pkg;

   // Result kinds on the output channel.
   localparam logic [1:0] KIND_BYTE      = 2'd0;
   localparam logic [1:0] KIND_END_TOKEN = 2'd1;
   localparam logic [1:0] KIND_END_LINE  = 2'd2;

   // Characters with a meaning of their own.
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_PIPE    = 8'h7C;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FFEED   = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;

   // Results per input word, and the depth of the queue between the two halves.
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Operator that may still be doubled by the next character.
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_AMP  = 2'd1,
      OP_GT   = 2'd2,
      OP_PIPE = 2'd3
   } op_type;

   // All results that one input word causes, in order.
   typedef struct packed {
      logic [1:0]                  count;
      logic [MAX_RESULTS-1:0][1:0] kinds;
      logic [MAX_RESULTS-1:0][7:0] bytes;
   } bundle_type;

   // Maps a character to its doubling operator code.
   function automatic op_type op_code(input logic [7:0] c);
      op_type r;
      case (c)
         CH_AMP:  r = OP_AMP;
         CH_GT:   r = OP_GT;
         CH_PIPE: r = OP_PIPE;
         default: r = OP_NONE;
      endcase
      return r;
   endfunction

   // Whitespace that ends a word in bare mode (newline is handled apart).
   function automatic logic is_blank(input logic [7:0] c);
      return c inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};
   endfunction

endpackage

>>> rtl/sct_front.sv
// Front end of the tokenizer: accepts one character word per cycle while accept
// is high, keeps the lexer state and turns each word into a bundle of up to
// three results. Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          ch,
   input  logic                end_of_input,
   output logic                push,
   output sct_pkg::bundle_type bundle
);

   logic            quote_ff, quote_in;
   logic            open_ff, open_in;
   sct_pkg::op_type pend_ff, pend_in;
   logic            lhc_ff, lhc_in;

   sct_pkg::op_type op;
   logic            do_close;
   logic [1:0]      cnt;

   // Classify the character and build the results it causes.
   always_comb begin
      quote_in = quote_ff;
      open_in  = open_ff;
      pend_in  = pend_ff;
      lhc_in   = lhc_ff;
      cnt      = 2'd0;
      bundle   = '0;
      op       = sct_pkg::op_code(ch);
      do_close = 1'b0;

      if (end_of_input || ch == sct_pkg::CH_NEWLINE) begin
         // End of line in any mode: close the token, then the line.
         if (open_ff) begin
            bundle.kinds[cnt] = sct_pkg::KIND_END_TOKEN;
            cnt = cnt + 2'd1;
         end
         if (open_ff || lhc_ff) begin
            bundle.kinds[cnt] = sct_pkg::KIND_END_LINE;
            cnt = cnt + 2'd1;
         end
         quote_in = 1'b0;
         open_in  = 1'b0;
         pend_in  = sct_pkg::OP_NONE;
         lhc_in   = 1'b0;
      end else if (quote_ff) begin
         // Quoted mode: everything but the closing quote is literal.
         if (ch == sct_pkg::CH_QUOTE) begin
            quote_in = 1'b0;
         end else begin
            bundle.kinds[cnt] = sct_pkg::KIND_BYTE;
            bundle.bytes[cnt] = ch;
            cnt = cnt + 2'd1;
            open_in = 1'b1;
         end
      end else if (pend_ff != sct_pkg::OP_NONE && op == pend_ff) begin
         // Doubled operator: emit the second character and end the token.
         bundle.kinds[cnt] = sct_pkg::KIND_BYTE;
         bundle.bytes[cnt] = ch;
         cnt = cnt + 2'd1;
         bundle.kinds[cnt] = sct_pkg::KIND_END_TOKEN;
         cnt = cnt + 2'd1;
         open_in = 1'b0;
         lhc_in  = 1'b1;
         pend_in = sct_pkg::OP_NONE;
      end else begin
         // Bare mode: first end the current token where needed.
         do_close = (pend_ff != sct_pkg::OP_NONE) || sct_pkg::is_blank(ch) ||
                    ch == sct_pkg::CH_LT || ch == sct_pkg::CH_COMMA ||
                    op != sct_pkg::OP_NONE;
         if (do_close) begin
            if (open_ff) begin
               bundle.kinds[cnt] = sct_pkg::KIND_END_TOKEN;
               cnt = cnt + 2'd1;
               lhc_in = 1'b1;
            end
            open_in = 1'b0;
            pend_in = sct_pkg::OP_NONE;
         end
         if (ch == sct_pkg::CH_QUOTE) begin
            quote_in = 1'b1;
         end else if (ch == sct_pkg::CH_LT || ch == sct_pkg::CH_COMMA) begin
            bundle.kinds[cnt] = sct_pkg::KIND_BYTE;
            bundle.bytes[cnt] = ch;
            cnt = cnt + 2'd1;
            bundle.kinds[cnt] = sct_pkg::KIND_END_TOKEN;
            cnt = cnt + 2'd1;
            lhc_in  = 1'b1;
            open_in = 1'b0;
         end else if (op != sct_pkg::OP_NONE) begin
            bundle.kinds[cnt] = sct_pkg::KIND_BYTE;
            bundle.bytes[cnt] = ch;
            cnt = cnt + 2'd1;
            open_in = 1'b1;
            pend_in = op;
         end else if (!sct_pkg::is_blank(ch)) begin
            bundle.kinds[cnt] = sct_pkg::KIND_BYTE;
            bundle.bytes[cnt] = ch;
            cnt = cnt + 2'd1;
            open_in = 1'b1;
         end
      end

      bundle.count = cnt;
   end

   // Only words that cause results enter the queue.
   assign push = accept && (cnt != 2'd0);

   // Lexer state advances on every accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff <= 1'b0;
         open_ff  <= 1'b0;
         pend_ff  <= sct_pkg::OP_NONE;
         lhc_ff   <= 1'b0;
      end else if (accept) begin
         quote_ff <= quote_in;
         open_ff  <= open_in;
         pend_ff  <= pend_in;
         lhc_ff   <= lhc_in;
      end
   end

endmodule

>>> rtl/sct_queue.sv
// Short queue of result bundles between the front and back ends of the tokenizer.
// Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sct_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                head_valid,
   output sct_pkg::bundle_type head,
   output logic                full
);

   sct_pkg::bundle_type              entry_ff [sct_pkg::QUEUE_DEPTH];
   logic [sct_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [sct_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [sct_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   // Status seen by both sides.
   assign full       = (count_ff == sct_pkg::QCNT_W'(sct_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Bundle storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/sct_back.sv
// Tokenizer back end: walks the head bundle one result per cycle unless stalled,
// into the output register; pops it with its last result. Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  sct_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_token_byte,
   output logic                rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;

   // Pick the next result of the head bundle when the output register frees up.
   always_comb begin
      load     = head_valid && (!valid_ff || !rsp_stall);
      kind_in  = head.kinds[idx_ff];
      byte_in  = head.bytes[idx_ff];
      last_in  = (idx_ff == head.count - 2'd1);
      pop      = load && last_in;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
      idx_in   = idx_ff;
      if (load) begin
         idx_in = last_in ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_token_byte = byte_ff;
   assign rsp_last       = last_ff;

endmodule

>>> rtl/shell_command_tokenizer_core.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_stall | req_ch[7:0], req_end_of_input
// rsp     | out       | rsp_valid, rsp_stall | rsp_kind[1:0], rsp_token_byte[7:0], rsp_last
//
// One character word is accepted per cycle while the four-entry bundle queue has room.
// Each word yields zero to three results; the back end delivers one result per cycle
// while rsp_stall is low, and input stalls whenever the queue is full.
// An accepted word passes through the bundle queue and the output register before its first result.
// Reset is synchronous and clears lexer state, queue pointers and the output valid.
// rsp_stall holds the output register; the queue keeps taking words until it fills.
// Top level of the tokenizer. Depends on sct_pkg, sct_front, sct_queue and sct_back.
`timescale 1ns / 1ps

module shell_command_tokenizer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last
);

   sct_pkg::bundle_type push_bundle;
   sct_pkg::bundle_type head;
   logic                push, pop, head_valid, full, accept;

   // A word is taken whenever the queue has room.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   sct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_ch),
      .end_of_input (req_end_of_input),
      .push         (push),
      .bundle       (push_bundle)
   );

   sct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_bundle),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .full       (full)
   );

   sct_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_token_byte (rsp_token_byte),
      .rsp_last       (rsp_last)
   );

endmodule

>>> rtl/sct_checker.sv
// Port-level checks for the tokenizer core, attached to it by a bind statement.
// Depends on sct_pkg and shell_command_tokenizer_core.
`timescale 1ns / 1ps

module sct_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_token_byte,
   input logic       rsp_last
);

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_token_byte) && $stable(rsp_last))
      else $error("stalled result changed");

   // An end of line always closes the results of its input word.
   a_eol_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sct_pkg::KIND_END_LINE |-> rsp_last)
      else $error("end of line not last result of its word");

   // Marks carry a zero byte.
   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != sct_pkg::KIND_BYTE |-> rsp_token_byte == 8'd0)
      else $error("mark with nonzero byte");

   // Quotes and newlines never appear inside a token.
   a_no_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sct_pkg::KIND_BYTE |->
      rsp_token_byte != sct_pkg::CH_QUOTE && rsp_token_byte != sct_pkg::CH_NEWLINE)
      else $error("quote or newline emitted as token byte");

endmodule

bind shell_command_tokenizer_core sct_checker u_sct_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_token_byte (rsp_token_byte),
   .rsp_last       (rsp_last)
);

>>> bench/tb.sv
// Self-checking testbench for shell_command_tokenizer_core: it predicts every token byte,
// token end and line end from the character stream and checks each result in order.
// Depends on sct_pkg and the tokenizer RTL only.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] tok_byte;
      logic       last;
   } token_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_token_byte;
   logic       rsp_last;

   // Expected results in arrival order, and the ones one word causes.
   token_result_type expected_results[$];
   token_result_type word_results[$];

   // Predicted lexer state.
   logic            quoted_mode = 1'b0;
   logic            word_open = 1'b0;
   sct_pkg::op_type pend_op = sct_pkg::OP_NONE;
   logic            line_content = 1'b0;

   int send_idle_pct = 17;
   int recv_idle_pct = 68;
   int hold_request = 0;
   int hold_left = 0;
   int mismatches = 0;
   int cycle_count = 0;

   shell_command_tokenizer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort the run if it takes far longer than any correct run could.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void add_result(input logic [1:0] kind, input logic [7:0] c);
      token_result_type r;
      r.kind     = kind;
      r.tok_byte = (kind == sct_pkg::KIND_BYTE) ? c : 8'h00;
      r.last     = 1'b0;
      word_results.push_back(r);
   endfunction

   function automatic void add_token_byte(input logic [7:0] c);
      add_result(sct_pkg::KIND_BYTE, c);
      word_open = 1'b1;
   endfunction

   function automatic void end_token();
      if (word_open) begin
         add_result(sct_pkg::KIND_END_TOKEN, 8'h00);
         word_open    = 1'b0;
         line_content = 1'b1;
      end
      pend_op = sct_pkg::OP_NONE;
   endfunction

   function automatic void end_line();
      end_token();
      if (line_content) begin
         add_result(sct_pkg::KIND_END_LINE, 8'h00);
      end
      line_content = 1'b0;
      quoted_mode  = 1'b0;
   endfunction

   function automatic sct_pkg::op_type doubling_op(input logic [7:0] c);
      sct_pkg::op_type r;
      case (c)
         sct_pkg::CH_AMP:  r = sct_pkg::OP_AMP;
         sct_pkg::CH_GT:   r = sct_pkg::OP_GT;
         sct_pkg::CH_PIPE: r = sct_pkg::OP_PIPE;
         default:          r = sct_pkg::OP_NONE;
      endcase
      return r;
   endfunction

   function automatic logic is_separator(input logic [7:0] c);
      return (c == sct_pkg::CH_SPACE) || (c == sct_pkg::CH_TAB) ||
             (c == sct_pkg::CH_VTAB) || (c == sct_pkg::CH_FFEED) ||
             (c == sct_pkg::CH_CR);
   endfunction

   // Works out the results of one accepted word and queues them.
   function automatic void tokenize_char(input logic [7:0] c, input logic eoi);
      sct_pkg::op_type op;
      logic            doubled;
      op      = doubling_op(c);
      doubled = 1'b0;
      word_results.delete();
      if (eoi) begin
         end_line();
      end else if (quoted_mode) begin
         if (c == sct_pkg::CH_NEWLINE) begin
            end_line();
         end else if (c == sct_pkg::CH_QUOTE) begin
            quoted_mode = 1'b0;
         end else begin
            add_token_byte(c);
         end
      end else begin
         // A pending operator is either doubled or closed before anything else.
         if (pend_op != sct_pkg::OP_NONE) begin
            if (op == pend_op) begin
               add_token_byte(c);
               end_token();
               doubled = 1'b1;
            end else begin
               end_token();
            end
         end
         if (!doubled) begin
            if (c == sct_pkg::CH_NEWLINE) begin
               end_line();
            end else if (is_separator(c)) begin
               end_token();
            end else if (c == sct_pkg::CH_QUOTE) begin
               quoted_mode = 1'b1;
            end else if ((c == sct_pkg::CH_LT) || (c == sct_pkg::CH_COMMA)) begin
               end_token();
               add_token_byte(c);
               end_token();
            end else if (op != sct_pkg::OP_NONE) begin
               end_token();
               add_token_byte(c);
               pend_op = op;
            end else begin
               add_token_byte(c);
            end
         end
      end
      if (word_results.size() != 0) begin
         word_results[word_results.size()-1].last = 1'b1;
      end
      foreach (word_results[i]) begin
         expected_results.push_back(word_results[i]);
      end
   endfunction

   // ---------------------------------------------------------------- channels

   // Offers one word, with random idle cycles before it, and predicts on acceptance.
   task automatic send_word(input logic [7:0] c, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ch           <= c;
      req_end_of_input <= eoi;
      do begin
         @(posedge clock);
      end while (req_stall);
      tokenize_char(c, eoi);
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      token_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual kind=%0d byte=%h last=%0d",
                     $time, rsp_kind, rsp_token_byte, rsp_last);
         end else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind) begin
               mismatches++;
               $display("%0t: kind mismatch, expected %0d, actual %0d",
                        $time, want.kind, rsp_kind);
            end
            if (rsp_token_byte !== want.tok_byte) begin
               mismatches++;
               $display("%0t: token byte mismatch, expected %h, actual %h",
                        $time, want.tok_byte, rsp_token_byte);
            end
            if (rsp_last !== want.last) begin
               mismatches++;
               $display("%0t: last mismatch, expected %0d, actual %0d",
                        $time, want.last, rsp_last);
            end
         end
      end
   end

   // Stops offering words and waits until every expected result has come.
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Picks a character, weighted toward shell-like text.
   task automatic pick_char(output logic [7:0] c, output logic eoi);
      int sel;
      sel = $urandom_range(99);
      eoi = 1'b0;
      if (sel < 38) begin
         c = 8'h61 + 8'($urandom_range(25));
      end else if (sel < 48) begin
         c = sct_pkg::CH_SPACE;
      end else if (sel < 52) begin
         case ($urandom_range(3))
            0:       c = sct_pkg::CH_TAB;
            1:       c = sct_pkg::CH_VTAB;
            2:       c = sct_pkg::CH_FFEED;
            default: c = sct_pkg::CH_CR;
         endcase
      end else if (sel < 72) begin
         case ($urandom_range(4))
            0:       c = sct_pkg::CH_AMP;
            1:       c = sct_pkg::CH_GT;
            2:       c = sct_pkg::CH_PIPE;
            3:       c = sct_pkg::CH_LT;
            default: c = sct_pkg::CH_COMMA;
         endcase
      end else if (sel < 80) begin
         c = sct_pkg::CH_QUOTE;
      end else if (sel < 87) begin
         c = sct_pkg::CH_NEWLINE;
      end else if (sel < 97) begin
         c = 8'($urandom_range(255));
      end else begin
         c   = 8'($urandom_range(255));
         eoi = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- tests

   // Words with extreme bytes, every kind of blank but the space, and an empty line.
   task automatic test_plain_words();
      send_word("a", 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(sct_pkg::CH_TAB, 1'b0);
      send_word(sct_pkg::CH_VTAB, 1'b0);
      send_word(sct_pkg::CH_FFEED, 1'b0);
      send_word(sct_pkg::CH_CR, 1'b0);
      send_word("b", 1'b0);
      send_word(sct_pkg::CH_NEWLINE, 1'b0);
      send_word(sct_pkg::CH_NEWLINE, 1'b0);
      wait_drain();
   endtask

   // Doubling, a third equal character, mixed pairs and single operators.
   task automatic test_operators();
      send_word(sct_pkg::CH_AMP, 1'b0);
      send_word(sct_pkg::CH_AMP, 1'b0);
      send_word(sct_pkg::CH_AMP, 1'b0);
      send_word(sct_pkg::CH_GT, 1'b0);
      send_word(sct_pkg::CH_PIPE, 1'b0);
      send_word(sct_pkg::CH_PIPE, 1'b0);
      send_word(sct_pkg::CH_LT, 1'b0);
      send_word(sct_pkg::CH_COMMA, 1'b0);
      send_word("x", 1'b0);
      send_word(sct_pkg::CH_GT, 1'b0);
      wait_drain();
   endtask

   // Quoted text with literal blanks and operators, empty quotes, and a newline
   // inside quotes; then end of input with a random character.
   task automatic test_quoted_text();
      send_word(sct_pkg::CH_QUOTE, 1'b0);
      send_word(sct_pkg::CH_SPACE, 1'b0);
      send_word(sct_pkg::CH_AMP, 1'b0);
      send_word(sct_pkg::CH_QUOTE, 1'b0);
      send_word("b", 1'b0);
      send_word(sct_pkg::CH_SPACE, 1'b0);
      send_word(sct_pkg::CH_QUOTE, 1'b0);
      send_word(sct_pkg::CH_QUOTE, 1'b0);
      send_word(sct_pkg::CH_QUOTE, 1'b0);
      send_word("q", 1'b0);
      send_word(sct_pkg::CH_NEWLINE, 1'b0);
      send_word("z", 1'b0);
      send_word(8'($urandom_range(255)), 1'b1);
      wait_drain();
   endtask

   // Random character stream under the given idle rates.
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      logic [7:0] c;
      logic       eoi;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) begin
         pick_char(c, eoi);
         send_word(c, eoi);
      end
      wait_drain();
   endtask

   // The receiver holds off for a long stretch while words keep coming, so the
   // internal queue fills and the input stalls.
   task automatic test_output_backpressure();
      logic [7:0] c;
      logic       eoi;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = HOLD_CYCLES;
      repeat (40) begin
         pick_char(c, eoi);
         send_word(c, eoi);
      end
      wait_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_plain_words();
      test_operators();
      test_quoted_text();
      test_random_traffic(70, 17, 68);
      test_random_traffic(70, 68, 17);
      test_random_traffic(50, 0, 0);
      test_output_backpressure();
      wait_drain();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/sct_pkg.sv
rtl/sct_front.sv
rtl/sct_queue.sv
rtl/sct_back.sv
rtl/shell_command_tokenizer_core.sv
rtl/sct_checker.sv
bench/tb.sv
